>>> src/hbs_pkg.sv
// shared types, constants and register codes for the heightmap bilinear sampler
package hbs_pkg;

    localparam int HBS_MAX_DIM   = 256;
    localparam int HBS_FRAC_BITS = 8;

    localparam int HBS_DIM_W    = 9;
    localparam int HBS_COORD_W  = 24;
    localparam int HBS_SCALE_W  = 16;
    localparam int HBS_PIX_W    = 8;
    localparam int HBS_HEIGHT_W = 24;
    localparam int HBS_IDX_W    = 3;
    localparam int HBS_DATA_W   = 16;
    localparam int HBS_KIND_W   = 2;

    localparam int HBS_MID_DEPTH = 8;
    localparam int HBS_OUT_DEPTH = 8;

    localparam logic [HBS_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [HBS_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [HBS_IDX_W-1:0] REG_INV_XZ_SCALE  = 3'd2;
    localparam logic [HBS_IDX_W-1:0] REG_HEIGHT_GAIN   = 3'd3;
    localparam logic [HBS_IDX_W-1:0] REG_HEIGHT_OFFSET = 3'd4;

    localparam logic [HBS_SCALE_W-1:0] RST_INV_XZ_SCALE  = 16'd6554;
    localparam logic [HBS_SCALE_W-1:0] RST_HEIGHT_GAIN   = 16'd1376;
    localparam logic [HBS_SCALE_W-1:0] RST_HEIGHT_OFFSET = 16'd4096;

    localparam logic [HBS_HEIGHT_W-1:0] HBS_HEIGHT_MISS = 24'hFFFE00;

    typedef enum logic [HBS_KIND_W-1:0] {
        KIND_LOAD,
        KIND_QUERY,
        KIND_MISS,
        KIND_DROP
    } hbs_kind_t;

    typedef struct packed {
        logic [HBS_DIM_W-1:0]   map_width;
        logic [HBS_DIM_W-1:0]   map_height;
        logic [HBS_SCALE_W-1:0] inverse_xz_scale;
        logic [HBS_SCALE_W-1:0] height_gain;
        logic [HBS_SCALE_W-1:0] height_offset;
    } hbs_cfg_t;

endpackage

>>> src/heightmap_bilinear_sampler.sv
// top level of the heightmap bilinear sampler: config registers, front, queue, back
// One request enters per clock, loads and queries alike, for as long as the result side keeps
// popping; a query's result reaches the result ports later when the queue between the front and
// back ends holds older requests. The front end registers the coordinate multiply, the range test
// and the row times width address multiply; the back end registers the store read, the row blend,
// the column blend and the gain multiply, and applies the final offset and saturation as the
// result enters the result queue. The four neighbors come out of four copies of the
// MAX_DIM*MAX_DIM byte store, one registered read port each, so a query needs only one store
// read; every load writes all four copies in request order with the queries. The store is not
// cleared after reset: read only pixels that were loaded. Loads produce no result.
// Configuration writes are taken at once and apply to later requests.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int MAX_DIM   = HBS_MAX_DIM,
    parameter int FRAC_BITS = HBS_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           mode,
    input  logic [15:0]                    pixel_index,
    input  logic [HBS_PIX_W-1:0]           pixel_value,
    input  logic signed [HBS_COORD_W-1:0]  world_x,
    input  logic signed [HBS_COORD_W-1:0]  world_z,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [HBS_HEIGHT_W-1:0] height,
    output logic                           out_of_range,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [HBS_IDX_W-1:0]           cfg_index,
    input  logic [HBS_DATA_W-1:0]          cfg_data
);

    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int MW  = HBS_KIND_W + AW + HBS_PIX_W + 2 * FRAC_BITS;
    localparam int QCW = $clog2(HBS_MID_DEPTH + 1);

    hbs_cfg_t       cfg_reg, cfg_next;
    logic           q_push, q_pop, q_empty;
    logic [MW-1:0]  q_wdata, q_rdata;
    logic [QCW-1:0] q_count;

    function automatic logic [HBS_DIM_W-1:0] clamp_dim(input logic [HBS_DIM_W-1:0] v);
        if (32'(v) > MAX_DIM)
        begin
            return HBS_DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:     cfg_next.map_width        = clamp_dim(cfg_data[HBS_DIM_W-1:0]);
                REG_MAP_HEIGHT:    cfg_next.map_height       = clamp_dim(cfg_data[HBS_DIM_W-1:0]);
                REG_INV_XZ_SCALE:  cfg_next.inverse_xz_scale = cfg_data;
                REG_HEIGHT_GAIN:   cfg_next.height_gain      = cfg_data;
                REG_HEIGHT_OFFSET: cfg_next.height_offset    = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width        <= '0;
            cfg_reg.map_height       <= '0;
            cfg_reg.inverse_xz_scale <= RST_INV_XZ_SCALE;
            cfg_reg.height_gain      <= RST_HEIGHT_GAIN;
            cfg_reg.height_offset    <= RST_HEIGHT_OFFSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hbs_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .world_x     (world_x),
        .world_z     (world_z),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    hbs_fifo #(.WIDTH(MW), .DEPTH(HBS_MID_DEPTH)) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    hbs_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .height       (height),
        .out_of_range (out_of_range)
    );

endmodule

>>> src/hbs_ram.sv
// generic single write, single read ram with registered read data
module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/hbs_fifo.sv
// small first-in first-out queue with show-ahead read and occupancy count
module hbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

>>> src/hbs_front.sv
// front end: accepts requests, scales query coordinates, classifies and forms addresses
module hbs_front import hbs_pkg::*; #(
    parameter int MAX_DIM   = HBS_MAX_DIM,
    parameter int FRAC_BITS = HBS_FRAC_BITS,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = $clog2(DEPTH),
    localparam int MW    = HBS_KIND_W + AW + HBS_PIX_W + 2 * FRAC_BITS,
    localparam int QCW   = $clog2(HBS_MID_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hbs_cfg_t                      cfg,
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic [15:0]                   pixel_index,
    input  logic [HBS_PIX_W-1:0]          pixel_value,
    input  logic signed [HBS_COORD_W-1:0] world_x,
    input  logic signed [HBS_COORD_W-1:0] world_z,
    input  logic [QCW-1:0]                q_count,
    output logic                          q_push,
    output logic [MW-1:0]                 q_data
);

    localparam int PW  = HBS_COORD_W + HBS_SCALE_W + 1;
    localparam int SH  = HBS_COORD_W - FRAC_BITS;
    localparam int LW  = PW - SH;
    localparam int GW  = LW + 1;
    localparam int LPW = GW - 1 - HBS_DIM_W - FRAC_BITS;
    localparam int HPW = GW - HBS_DIM_W - FRAC_BITS + 1;
    localparam int EW  = (AW > 2 * HBS_DIM_W) ? AW : 2 * HBS_DIM_W;

    logic accept;

    // stage 1: coordinate products
    logic                       v1_reg;
    logic                       mode1_reg;
    logic [15:0]                idx1_reg;
    logic [HBS_PIX_W-1:0]       val1_reg;
    logic signed [PW-1:0]       px1_reg, pz1_reg;
    logic signed [HBS_SCALE_W:0] scale_s;

    // stage 2: grid position and classification
    logic                       v2_reg;
    hbs_kind_t                  kind2_reg, kind2_next;
    logic [HBS_DIM_W-1:0]       row2_reg, col2_reg;
    logic [FRAC_BITS-1:0]       fi2_reg, fj2_reg;
    logic [15:0]                idx2_reg;
    logic [HBS_PIX_W-1:0]       val2_reg;

    // stage 3: store address
    logic                       v3_reg;
    hbs_kind_t                  kind3_reg;
    logic [AW-1:0]              addr3_reg;
    logic [HBS_PIX_W-1:0]       val3_reg;
    logic [FRAC_BITS-1:0]       fi3_reg, fj3_reg;

    logic signed [LW-1:0]       loc_x, loc_z;
    logic [GW-1:0]              grid_x, grid_z;
    logic [HBS_DIM_W-1:0]       hm1, wm1;
    logic [GW-2:0]              lim_x, lim_z;
    logic                       in_x, in_z, no_map;
    logic [2*HBS_DIM_W-1:0]     row_base;
    logic [EW-1:0]              addr_ext;
    logic [QCW:0]               occupancy;

    assign occupancy = (QCW + 1)'(q_count) + (QCW + 1)'(v1_reg) + (QCW + 1)'(v2_reg)
                     + (QCW + 1)'(v3_reg);
    assign full      = (occupancy >= (QCW + 1)'(HBS_MID_DEPTH));
    assign accept    = push && !full;
    assign scale_s   = $signed({1'b0, cfg.inverse_xz_scale});

    // floor of the scaled coordinate is an arithmetic shift
    assign loc_x  = px1_reg[PW-1:SH];
    assign loc_z  = pz1_reg[PW-1:SH];
    assign grid_x = {loc_x[LW-1], loc_x}
                  + {{HPW{1'b0}}, cfg.map_height, {(FRAC_BITS-1){1'b0}}};
    assign grid_z = {loc_z[LW-1], loc_z}
                  + {{HPW{1'b0}}, cfg.map_width, {(FRAC_BITS-1){1'b0}}};
    assign hm1    = cfg.map_height - 9'd1;
    assign wm1    = cfg.map_width - 9'd1;
    assign lim_x  = {{LPW{1'b0}}, hm1, {FRAC_BITS{1'b0}}};
    assign lim_z  = {{LPW{1'b0}}, wm1, {FRAC_BITS{1'b0}}};
    assign in_x   = !grid_x[GW-1] && (grid_x[GW-2:0] < lim_x);
    assign in_z   = !grid_z[GW-1] && (grid_z[GW-2:0] < lim_z);
    assign no_map = (cfg.map_width == '0) || (cfg.map_height == '0);

    always_comb
    begin
        if (mode1_reg)
        begin
            kind2_next = (!no_map && in_x && in_z) ? KIND_QUERY : KIND_MISS;
        end
        else
        begin
            kind2_next = (32'(idx1_reg) < DEPTH) ? KIND_LOAD : KIND_DROP;
        end
    end

    assign row_base = row2_reg * cfg.map_width;

    always_comb
    begin
        if (kind2_reg == KIND_LOAD)
        begin
            addr_ext = EW'(idx2_reg);
        end
        else
        begin
            addr_ext = EW'(row_base) + EW'(col2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        idx1_reg  <= pixel_index;
        val1_reg  <= pixel_value;
        px1_reg   <= world_x * scale_s;
        pz1_reg   <= world_z * scale_s;

        kind2_reg <= kind2_next;
        row2_reg  <= grid_x[FRAC_BITS +: HBS_DIM_W];
        col2_reg  <= grid_z[FRAC_BITS +: HBS_DIM_W];
        fi2_reg   <= grid_x[FRAC_BITS-1:0];
        fj2_reg   <= grid_z[FRAC_BITS-1:0];
        idx2_reg  <= idx1_reg;
        val2_reg  <= val1_reg;

        kind3_reg <= kind2_reg;
        addr3_reg <= addr_ext[AW-1:0];
        val3_reg  <= val2_reg;
        fi3_reg   <= fi2_reg;
        fj3_reg   <= fj2_reg;
    end

    assign q_push = v3_reg && (kind3_reg != KIND_DROP);
    assign q_data = {kind3_reg, addr3_reg, val3_reg, fi3_reg, fj3_reg};

endmodule

>>> src/hbs_back.sv
// back end: store access, bilinear blend, gain and offset, result queue
module hbs_back import hbs_pkg::*; #(
    parameter int MAX_DIM   = HBS_MAX_DIM,
    parameter int FRAC_BITS = HBS_FRAC_BITS,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = $clog2(DEPTH),
    localparam int MW    = HBS_KIND_W + AW + HBS_PIX_W + 2 * FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hbs_cfg_t                       cfg,
    input  logic                           q_empty,
    input  logic [MW-1:0]                  q_data,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic signed [HBS_HEIGHT_W-1:0] height,
    output logic                           out_of_range
);

    localparam int F   = FRAC_BITS;
    localparam int HW  = HBS_PIX_W + F;
    localparam int BW  = HBS_PIX_W + 2 * F;
    localparam int SPW = HBS_HEIGHT_W + 2 * F;
    localparam int RW  = HBS_HEIGHT_W + 2;
    localparam int OW  = HBS_HEIGHT_W + 1;
    localparam int CW  = $clog2(HBS_OUT_DEPTH + 1);
    localparam logic signed [RW-1:0] BIAS   = 26'sd512;
    localparam logic signed [RW-1:0] SAT_HI = 26'sd8388607;
    localparam logic signed [RW-1:0] SAT_LO = -26'sd8388608;

    hbs_kind_t            hk;
    logic [AW-1:0]        haddr, a01, a10, a11;
    logic [HBS_PIX_W-1:0] hval;
    logic [F-1:0]         hfi, hfj;
    logic                 issue_q, load_we;
    logic [CW-1:0]        out_count;
    logic [CW:0]          busy;

    logic [HBS_PIX_W-1:0] p00, p01, p10, p11;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 miss1_reg, miss2_reg, miss3_reg, miss4_reg;
    logic [F-1:0]         fi1_reg, fj1_reg, fj2_reg;
    logic [HW-1:0]        h0_2_reg, h1_2_reg;
    logic [BW-1:0]        blend3_reg;
    logic [HBS_HEIGHT_W-1:0] sc4_reg;

    logic signed [HBS_PIX_W:0]   d0, d1;
    logic signed [F:0]           sfi, sfj;
    logic signed [HW+1:0]        m0, m1, s0, s1;
    logic signed [HW:0]          dh;
    logic signed [BW+1:0]        mb, sb;
    logic [SPW-1:0]              sp;
    logic signed [RW-1:0]        r;
    logic [HBS_HEIGHT_W-1:0]     sat;
    logic [OW-1:0]               out_word, out_rdata;

    assign hk    = hbs_kind_t'(q_data[MW-1 -: HBS_KIND_W]);
    assign haddr = q_data[MW-HBS_KIND_W-1 -: AW];
    assign hval  = q_data[2*F +: HBS_PIX_W];
    assign hfi   = q_data[F +: F];
    assign hfj   = q_data[F-1:0];

    // loads need no result slot, queries and misses reserve one
    assign busy    = (CW + 1)'(out_count) + (CW + 1)'(v1_reg) + (CW + 1)'(v2_reg)
                   + (CW + 1)'(v3_reg) + (CW + 1)'(v4_reg);
    assign q_pop   = !q_empty && ((hk == KIND_LOAD) || (busy < (CW + 1)'(HBS_OUT_DEPTH)));
    assign issue_q = q_pop && (hk != KIND_LOAD);
    assign load_we = q_pop && (hk == KIND_LOAD);

    assign a01 = haddr + AW'(1);
    assign a10 = haddr + AW'(cfg.map_width);
    assign a11 = haddr + AW'(cfg.map_width + 9'd1);

    // one copy of the store per neighbor, every load writes all four
    hbs_ram #(.WIDTH(HBS_PIX_W), .DEPTH(DEPTH)) u_ram00 (
        .clk(clk), .we(load_we), .waddr(haddr), .wdata(hval), .raddr(haddr), .rdata(p00)
    );
    hbs_ram #(.WIDTH(HBS_PIX_W), .DEPTH(DEPTH)) u_ram01 (
        .clk(clk), .we(load_we), .waddr(haddr), .wdata(hval), .raddr(a01), .rdata(p01)
    );
    hbs_ram #(.WIDTH(HBS_PIX_W), .DEPTH(DEPTH)) u_ram10 (
        .clk(clk), .we(load_we), .waddr(haddr), .wdata(hval), .raddr(a10), .rdata(p10)
    );
    hbs_ram #(.WIDTH(HBS_PIX_W), .DEPTH(DEPTH)) u_ram11 (
        .clk(clk), .we(load_we), .waddr(haddr), .wdata(hval), .raddr(a11), .rdata(p11)
    );

    // blend along rows
    assign d0  = $signed({1'b0, p10}) - $signed({1'b0, p00});
    assign d1  = $signed({1'b0, p11}) - $signed({1'b0, p01});
    assign sfi = $signed({1'b0, fi1_reg});
    assign m0  = d0 * sfi;
    assign m1  = d1 * sfi;
    assign s0  = $signed({2'b00, p00, {F{1'b0}}}) + m0;
    assign s1  = $signed({2'b00, p01, {F{1'b0}}}) + m1;

    // blend along columns
    assign dh  = $signed({1'b0, h1_2_reg}) - $signed({1'b0, h0_2_reg});
    assign sfj = $signed({1'b0, fj2_reg});
    assign mb  = dh * sfj;
    assign sb  = $signed({2'b00, h0_2_reg, {F{1'b0}}}) + mb;

    assign sp = blend3_reg * cfg.height_gain;

    assign r = $signed({2'b00, sc4_reg}) - $signed({10'b0, cfg.height_offset}) - BIAS;

    always_comb
    begin
        if (r > SAT_HI)
        begin
            sat = SAT_HI[HBS_HEIGHT_W-1:0];
        end
        else if (r < SAT_LO)
        begin
            sat = SAT_LO[HBS_HEIGHT_W-1:0];
        end
        else
        begin
            sat = r[HBS_HEIGHT_W-1:0];
        end
        out_word = miss4_reg ? {1'b1, HBS_HEIGHT_MISS} : {1'b0, sat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue_q;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        miss1_reg  <= (hk == KIND_MISS);
        fi1_reg    <= hfi;
        fj1_reg    <= hfj;

        miss2_reg  <= miss1_reg;
        fj2_reg    <= fj1_reg;
        h0_2_reg   <= s0[HW-1:0];
        h1_2_reg   <= s1[HW-1:0];

        miss3_reg  <= miss2_reg;
        blend3_reg <= sb[BW-1:0];

        miss4_reg  <= miss3_reg;
        sc4_reg    <= sp[SPW-1:2*F];
    end

    hbs_fifo #(.WIDTH(OW), .DEPTH(HBS_OUT_DEPTH)) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (v4_reg),
        .wdata (out_word),
        .pop   (pop && !empty),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign height       = out_rdata[HBS_HEIGHT_W-1:0];
    assign out_of_range = out_rdata[HBS_HEIGHT_W];

endmodule

>>> src/hbs_checker.sv
// port-level checks on the heightmap bilinear sampler, bound to the top level
module hbs_checker import hbs_pkg::*; (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic signed [HBS_HEIGHT_W-1:0] height,
    input logic                           out_of_range
);

    a_reset_empty: assert property (@(posedge clk) (!rst_n ##1 !rst_n) |-> empty)
        else $error("result queue not empty during reset");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_of_range) |-> (height == HBS_HEIGHT_MISS))
        else $error("out of range result without -2.0 height");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(height) && $stable(out_of_range)))
        else $error("waiting result changed");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose with no request taken");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_checker (.*);
